// ----- design/signed_binary_to_decimal_ascii_top_assert.svh -----
// Assertion macros used by the checker file of the decimal text converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sbdc_pkg.sv -----
// Package of types and constants for the binary to decimal text converter.
package sbdc_pkg;

	localparam int VALUE_BITS   = 32;
	localparam int IN_VALUE_W   = 32;
	// Decimal digits needed for the largest magnitude: floor(N * log10(2)) + 1.
	localparam int NUM_DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BIT_CNT_W    = $clog2(VALUE_BITS);
	localparam int REM_W        = $clog2(NUM_DIGITS + 1);
	localparam int IDX_W        = $clog2(NUM_DIGITS + 2);
	localparam int CHAR_W       = 7;
	localparam int CHAR_INDEX_W = 4;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
	localparam logic [3:0]        RADIX    = 4'd10;
	// Double-dabble correction: a digit of RADIX/2 or more gets RADIX/2 - 2 added.
	localparam logic [3:0]        DIGIT_ADJ_MIN = RADIX >> 1;
	localparam logic [3:0]        DIGIT_ADJ     = (RADIX >> 1) - 4'd2;

	typedef struct packed {
		logic [IN_VALUE_W-1:0] value;
		logic                  is_signed;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]       character;
		logic [CHAR_INDEX_W-1:0] char_index;
		logic                    last;
		logic [CHAR_INDEX_W-1:0] char_count;
	} res_item_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic shift;
	} cell_ctrl_t;

endpackage

// ----- design/sbdc_cell.sv -----
// One BCD digit cell: clear, double-dabble step or digit shift towards the top.
module sbdc_cell import sbdc_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       bit_in,
	input  logic [3:0] digit_in,
	output logic       carry_out,
	output logic [3:0] digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	assign adj       = (digit_q >= DIGIT_ADJ_MIN) ? (digit_q + DIGIT_ADJ) : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.step) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ----- design/sbdc_chain.sv -----
// Row of BCD digit cells, least significant digit at index zero.
module sbdc_chain import sbdc_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       bit_in,
	output logic [3:0] top_digit
);

	logic [NUM_DIGITS-1:0] carry;
	logic [3:0]            digit [NUM_DIGITS];

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_bottom
			sbdc_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.bit_in    (bit_in),
				.digit_in  (4'd0),
				.carry_out (carry[i]),
				.digit     (digit[i])
			);
		end else begin : g_upper
			sbdc_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.bit_in    (carry[i-1]),
				.digit_in  (digit[i-1]),
				.carry_out (carry[i]),
				.digit     (digit[i])
			);
		end
	end

	assign top_digit = digit[NUM_DIGITS-1];

endmodule

// ----- design/signed_binary_to_decimal_ascii_top.sv -----
// Converts a signed or unsigned binary value into its decimal ASCII text, one character per item.
// The block works on one number at a time. After an item is accepted, the magnitude is shifted
// one bit per cycle into a row of BCD digit cells, leading zero digits are then shifted out at
// one per cycle, and the characters leave one per cycle while the output is not stalled, minus
// sign first. The last character sits in an output register, so the next number is accepted
// while it waits to be taken.
module signed_binary_to_decimal_ascii_top import sbdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output res_item_t result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [REM_W-1:0]      rem_q;
	logic [IDX_W-1:0]      pos_q;
	logic                  result_valid_q;
	res_item_t             result_q;

	logic [VALUE_BITS-1:0] v_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  accept;
	logic                  out_free;
	logic                  emit_now;
	logic                  skip_now;
	logic                  last_now;
	logic [3:0]            top_digit;
	cell_ctrl_t            ctrl;

	assign v_in     = VALUE_BITS'(item.value);
	assign neg_in   = item.is_signed & v_in[VALUE_BITS-1];
	assign mag_in   = neg_in ? (~v_in + VALUE_BITS'(1)) : v_in;
	assign item_ready = (state_q == ST_IDLE);
	assign accept   = item_valid & item_ready;
	assign out_free = ~result_valid_q | result_ready;
	assign emit_now = out_free && ((state_q == ST_SIGN) || (state_q == ST_EMIT));
	assign skip_now = (top_digit == 4'd0) && (rem_q != REM_W'(1));
	assign last_now = (rem_q == REM_W'(1));

	assign ctrl.clear = accept;
	assign ctrl.step  = (state_q == ST_CONV);
	assign ctrl.shift = ((state_q == ST_SKIP) && skip_now) || ((state_q == ST_EMIT) && out_free);

	sbdc_chain u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.bit_in    (mag_q[VALUE_BITS-1]),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mag_q          <= '0;
			neg_q          <= 1'b0;
			bit_cnt_q      <= '0;
			rem_q          <= '0;
			pos_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (emit_now) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mag_q     <= mag_in;
						neg_q     <= neg_in;
						bit_cnt_q <= BIT_CNT_W'(VALUE_BITS - 1);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					mag_q <= mag_q << 1;
					if (bit_cnt_q == '0) begin
						rem_q   <= REM_W'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end else begin
						bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					end
				end
				ST_SKIP: begin
					pos_q <= '0;
					if (skip_now) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						result_q.character  <= CH_MINUS;
						result_q.char_index <= '0;
						result_q.last       <= 1'b0;
						result_q.char_count <= '0;
						pos_q               <= IDX_W'(1);
						state_q             <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						result_q.character  <= CH_ZERO + CHAR_W'(top_digit);
						result_q.char_index <= CHAR_INDEX_W'(pos_q);
						result_q.last       <= last_now;
						result_q.char_count <= last_now ?
							CHAR_INDEX_W'(pos_q + IDX_W'(1)) : '0;
						rem_q               <= rem_q - REM_W'(1);
						pos_q               <= pos_q + IDX_W'(1);
						if (last_now) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- design/sbdc_checker.sv -----
// Port-level checker for the decimal text converter, bound to the top level.
`include "signed_binary_to_decimal_ascii_top_assert.svh"

module sbdc_checker import sbdc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_ready,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_ready,
	input res_item_t result
);

	logic stalled;
	logic is_digit;

	assign stalled  = result_valid & ~result_ready;
	assign is_digit = (result.character >= CH_ZERO) && (result.character <= (CH_ZERO + 7'd9));

	`SBDC_ASSERT_NEXT(a_result_held, clk, arst_n, stalled, result_valid && $stable(result), "result item dropped or changed while stalled")
	`SBDC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && item_ready, !item_ready, "new item accepted during a conversion")
	`SBDC_ASSERT_NOW(a_char_legal, clk, arst_n, result_valid, (result.character == CH_MINUS) || is_digit, "character is neither a digit nor a minus sign")
	`SBDC_ASSERT_NOW(a_count_on_last, clk, arst_n, result_valid && result.last, (result.char_count == result.char_index + 4'd1) && is_digit, "bad count or character on last item")
	`SBDC_ASSERT_NOW(a_count_zero, clk, arst_n, result_valid && !result.last, result.char_count == 4'd0, "char_count set on an item that is not last")

endmodule

bind signed_binary_to_decimal_ascii_top sbdc_checker u_sbdc_checker (.*);
